FILE: hw/rtl/lir_pkg.sv
// Shared types, widths and constants of the linear interpolation resampler.
// No dependencies; every other file of the block imports it.
package lir_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int MAX_RESULTS = 16;
    localparam int RATE_W      = 19;
    localparam int GAP_W       = RATE_W + 1;
    localparam int ACC_W       = SAMPLE_W + RATE_W + 1;
    localparam int DIV_NW      = ACC_W;
    localparam int DIV_DW      = RATE_W + 1;
    localparam int DIV_CW      = $clog2(DIV_NW + 1);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int Q_DEPTH     = 2;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int Q_CW        = $clog2(Q_DEPTH + 1);
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [RATE_W-1:0] SRC_RESET = RATE_W'(48000);
    localparam logic [RATE_W-1:0] TGT_RESET = RATE_W'(16000);

    // register select, taken from paddr[2]
    localparam logic REG_SRC_SEL = 1'b0;
    localparam logic REG_TGT_SEL = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       stream_end;
        logic                       has_prev;
    } t_item;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
        logic [DIV_DW-1:0] rem;
    } t_div_rsp;

    // next output position lies at or before the inputs received
    function automatic logic f_released(input logic signed [GAP_W-1:0] gap,
                                        input logic [RATE_W-1:0] rem);
        return gap[GAP_W-1] || (gap == '0 && rem == '0);
    endfunction

endpackage

FILE: hw/rtl/linear_interp_resampler_unit.sv
// Linear interpolation resampler, top level: APB rate registers, front end, queue,
// back end and shared divider. Depends on lir_pkg, lir_front, lir_queue, lir_div, lir_back.
// An input that yields no result passes S_IDLE, S_LOOP (S_END if it ends a stream) and S_OUT;
// each interpolated result takes two 36-step passes through the shared divider (value, then
// advance). Results leave one per cycle from the back end buffer while the output is ready.
// Synchronous active-low reset: rates to 48000 / 16000, stream position and queue cleared.
module linear_interp_resampler_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lir_pkg::ADDR_W-1:0]          paddr,
    input  logic [lir_pkg::DATA_W-1:0]          pwdata,
    output logic [lir_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                i_stream_end,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [lir_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                o_run_last,
    output logic                                o_stream_done,
    output logic                                o_overflow_dropped
);
    import lir_pkg::*;

    logic [RATE_W-1:0] r_src_rate;
    logic [RATE_W-1:0] r_tgt_rate;
    logic [RATE_W-1:0] w_src_eff;
    logic [RATE_W-1:0] w_tgt_eff;
    logic              w_cfg_wr;
    logic              w_push;
    logic              w_pop;
    logic              w_q_full;
    logic              w_q_valid;
    t_item             w_in_item;
    t_item             w_q_item;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_src_eff = (r_src_rate == '0) ? RATE_W'(1) : r_src_rate;
    assign w_tgt_eff = (r_tgt_rate == '0) ? RATE_W'(1) : r_tgt_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_rate <= SRC_RESET;
            r_tgt_rate <= TGT_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_SRC_SEL: r_src_rate <= pwdata[RATE_W-1:0];
                REG_TGT_SEL: r_tgt_rate <= pwdata[RATE_W-1:0];
                default:     r_src_rate <= r_src_rate;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SRC_SEL: prdata = DATA_W'(r_src_rate);
            REG_TGT_SEL: prdata = DATA_W'(r_tgt_rate);
            default:     prdata = '0;
        endcase
    end

    lir_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clr        (w_cfg_wr),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .i_stream_end (i_stream_end),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_item       (w_in_item)
    );

    lir_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    lir_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    lir_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_clr              (w_cfg_wr),
        .i_src_rate         (w_src_eff),
        .i_tgt_rate         (w_tgt_eff),
        .i_q_valid          (w_q_valid),
        .i_q_item           (w_q_item),
        .o_q_pop            (w_pop),
        .o_div_req          (w_div_req),
        .i_div_rsp          (w_div_rsp),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_sample_out       (o_sample_out),
        .o_run_last         (o_run_last),
        .o_stream_done      (o_stream_done),
        .o_overflow_dropped (o_overflow_dropped)
    );

endmodule

FILE: hw/rtl/lir_front.sv
// Front end: accepts input transactions and tags each with its stream context.
// Depends on lir_pkg.
module lir_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clr,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                           i_stream_end,
    input  logic                           i_q_full,
    output logic                           o_push,
    output lir_pkg::t_item                 o_item
);
    import lir_pkg::*;

    logic r_has_prev;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_item.sample     = i_sample_in;
        o_item.stream_end = i_stream_end;
        o_item.has_prev   = r_has_prev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_prev <= 1'b0;
        end else if (i_clr) begin
            r_has_prev <= 1'b0;
        end else if (o_push) begin
            r_has_prev <= !i_stream_end;
        end
    end

endmodule

FILE: hw/rtl/lir_queue.sv
// Small FIFO of tagged items between the front end and the back end.
// Depends on lir_pkg.
module lir_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lir_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output lir_pkg::t_item o_item,
    input  logic           i_pop
);
    import lir_pkg::*;

    t_item            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp;
    logic [Q_AW-1:0]  r_rp;
    logic [Q_CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + Q_CW'(1);
                2'b01:   r_cnt <= r_cnt - Q_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: hw/rtl/lir_div.sv
// Shared restoring divider, one quotient bit per cycle, unsigned.
// Depends on lir_pkg.
module lir_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lir_pkg::t_div_req i_req,
    output lir_pkg::t_div_rsp o_rsp
);
    import lir_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   w_sh;
    logic [DIV_DW:0]   w_diff;
    logic              w_ge;

    assign w_sh   = {r_rem, r_quo[DIV_NW-1]};
    assign w_ge   = (w_sh >= {1'b0, r_den});
    assign w_diff = w_sh - {1'b0, r_den};

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIV_DW-1:0] : w_sh[DIV_DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/lir_back.sv
// Back end: position tracking, interpolation, end-of-stream tail, result buffer
// and output register. Depends on lir_pkg and uses lir_div through its ports.
module lir_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clr,
    input  logic [lir_pkg::RATE_W-1:0]          i_src_rate,
    input  logic [lir_pkg::RATE_W-1:0]          i_tgt_rate,
    input  logic                                i_q_valid,
    input  lir_pkg::t_item                      i_q_item,
    output logic                                o_q_pop,
    output lir_pkg::t_div_req                   o_div_req,
    input  lir_pkg::t_div_rsp                   i_div_rsp,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [lir_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                o_run_last,
    output logic                                o_stream_done,
    output logic                                o_overflow_dropped
);
    import lir_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOP, S_SKIP, S_MUL1, S_MUL2, S_ABS, S_IDIV, S_ADV, S_END, S_OUT
    } t_state;

    localparam logic signed [GAP_W-1:0] GAP_ONE = GAP_W'(1);
    localparam logic signed [GAP_W-1:0] GAP_M1  = GAP_W'(-1);
    localparam logic signed [GAP_W-1:0] GAP_M2  = GAP_W'(-2);

    t_state                     r_state;
    t_item                      r_item;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic signed [GAP_W-1:0]    r_gap;
    logic [RATE_W-1:0]          r_rem;
    logic                       r_pend_v;
    logic signed [SAMPLE_W-1:0] r_pend;
    logic [CNT_W-1:0]           r_cnt;
    logic [IDX_W-1:0]           r_idx;
    logic                       r_over;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_neg;
    logic signed [SAMPLE_W-1:0] r_val;
    logic signed [SAMPLE_W-1:0] r_buf [MAX_RESULTS];
    logic                       r_div_start;
    logic [DIV_NW-1:0]          r_div_num;
    logic [DIV_DW-1:0]          r_div_den;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_last;
    logic                       r_out_done;
    logic                       r_out_over;

    logic signed [GAP_W-1:0]    w_gap_dec;
    logic signed [GAP_W-1:0]    w_gap_adv;
    logic [RATE_W-1:0]          w_rem_adv;
    logic [RATE_W-1:0]          w_skip_rem;
    logic [RATE_W-1:0]          w_tmr;
    logic [RATE_W:0]            w_sum;
    logic [ACC_W-1:0]           w_mag;
    logic [ACC_W-1:0]           w_inum;
    logic [SAMPLE_W:0]          w_q;
    logic [SAMPLE_W:0]          w_qs;
    logic                       w_loop;
    logic                       w_end_go;
    logic                       w_full;
    logic                       w_last;
    logic                       w_out_free;
    logic [IDX_W-1:0]           w_widx;

    assign w_gap_dec  = r_gap - GAP_ONE;
    assign w_gap_adv  = r_gap + $signed({1'b0, i_div_rsp.quo[RATE_W-1:0]});
    assign w_rem_adv  = i_div_rsp.rem[RATE_W-1:0];
    assign w_skip_rem = (i_div_rsp.rem == '0) ? '0 : i_src_rate - i_div_rsp.rem[RATE_W-1:0];
    assign w_tmr      = i_tgt_rate - r_rem;
    assign w_sum      = {1'b0, r_rem} + {1'b0, i_src_rate};
    assign w_mag      = r_acc[ACC_W-1] ? $unsigned(-r_acc) : $unsigned(r_acc);
    assign w_inum     = {w_mag[ACC_W-2:0], 1'b0} + ACC_W'(i_tgt_rate);
    assign w_q        = i_div_rsp.quo[SAMPLE_W:0];
    assign w_qs       = r_neg ? ((SAMPLE_W+1)'(0) - w_q) : w_q;
    assign w_loop     = r_item.has_prev && (r_gap == GAP_M2);
    assign w_end_go   = (r_gap == GAP_M1) && (w_sum <= {1'b0, i_tgt_rate});
    assign w_full     = (r_cnt == CNT_W'(MAX_RESULTS));
    assign w_last     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_cnt);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_widx     = r_cnt[IDX_W-1:0];

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid && !i_clr;

    assign o_div_req.start = r_div_start;
    assign o_div_req.num   = r_div_num;
    assign o_div_req.den   = r_div_den;

    assign o_out_valid        = r_out_valid;
    assign o_sample_out       = r_out_sample;
    assign o_run_last         = r_out_last;
    assign o_stream_done      = r_out_done;
    assign o_overflow_dropped = r_out_over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gap       <= '0;
            r_rem       <= '0;
            r_pend_v    <= 1'b0;
            r_prev      <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_over      <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_clr) begin
                r_gap    <= '0;
                r_rem    <= '0;
                r_pend_v <= 1'b0;
                r_prev   <= '0;
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (i_q_valid) begin
                            r_item <= i_q_item;
                            r_gap  <= w_gap_dec;
                            r_cnt  <= '0;
                            r_idx  <= '0;
                            r_over <= 1'b0;
                            if (r_pend_v) begin
                                if (f_released(w_gap_dec, r_rem)) begin
                                    r_buf[0] <= r_pend;
                                    r_cnt    <= CNT_W'(1);
                                    r_pend_v <= 1'b0;
                                end else if (i_q_item.stream_end) begin
                                    r_pend_v <= 1'b0;
                                end
                            end
                            r_state <= S_LOOP;
                        end
                    end
                    S_LOOP: begin
                        if (w_loop) begin
                            if (w_full && (i_src_rate < i_tgt_rate)) begin
                                // all outputs left at this index are due: skip them
                                r_over      <= 1'b1;
                                r_div_start <= 1'b1;
                                r_div_num   <= DIV_NW'(w_tmr);
                                r_div_den   <= DIV_DW'(i_src_rate);
                                r_state     <= S_SKIP;
                            end else begin
                                r_state <= S_MUL1;
                            end
                        end else if (r_item.stream_end) begin
                            r_state <= S_END;
                        end else begin
                            r_prev  <= r_item.sample;
                            r_state <= S_OUT;
                        end
                    end
                    S_SKIP: begin
                        if (i_div_rsp.done) begin
                            r_rem   <= w_skip_rem;
                            r_gap   <= r_gap + GAP_ONE;
                            r_state <= S_LOOP;
                        end
                    end
                    S_MUL1: begin
                        r_acc   <= ACC_W'(r_prev) * ACC_W'($signed({1'b0, w_tmr}));
                        r_state <= S_MUL2;
                    end
                    S_MUL2: begin
                        r_acc   <= r_acc + ACC_W'($signed(r_item.sample)) *
                                           ACC_W'($signed({1'b0, r_rem}));
                        r_state <= S_ABS;
                    end
                    S_ABS: begin
                        r_neg       <= r_acc[ACC_W-1];
                        r_div_start <= 1'b1;
                        r_div_num   <= w_inum;
                        r_div_den   <= {i_tgt_rate, 1'b0};
                        r_state     <= S_IDIV;
                    end
                    S_IDIV: begin
                        if (i_div_rsp.done) begin
                            r_val       <= w_qs[SAMPLE_W-1:0];
                            r_div_start <= 1'b1;
                            r_div_num   <= DIV_NW'(i_src_rate) + DIV_NW'(r_rem);
                            r_div_den   <= {1'b0, i_tgt_rate};
                            r_state     <= S_ADV;
                        end
                    end
                    S_ADV: begin
                        if (i_div_rsp.done) begin
                            r_gap <= w_gap_adv;
                            r_rem <= w_rem_adv;
                            if (f_released(w_gap_adv, w_rem_adv)) begin
                                if (!w_full) begin
                                    r_buf[w_widx] <= r_val;
                                    r_cnt         <= r_cnt + CNT_W'(1);
                                end else begin
                                    r_over <= 1'b1;
                                end
                            end else if (!r_item.stream_end) begin
                                r_pend   <= r_val;
                                r_pend_v <= 1'b1;
                            end
                            r_state <= S_LOOP;
                        end
                    end
                    S_END: begin
                        if (w_end_go && !w_full) begin
                            // tail past the last pair repeats the final sample
                            r_buf[w_widx] <= r_item.sample;
                            r_cnt         <= r_cnt + CNT_W'(1);
                            if (w_sum == {1'b0, i_tgt_rate}) begin
                                r_gap <= '0;
                                r_rem <= '0;
                            end else begin
                                r_rem <= w_sum[RATE_W-1:0];
                            end
                        end else begin
                            if (w_end_go) begin
                                r_over <= 1'b1;
                            end
                            r_gap    <= '0;
                            r_rem    <= '0;
                            r_pend_v <= 1'b0;
                            r_prev   <= '0;
                            r_state  <= S_OUT;
                        end
                    end
                    S_OUT: begin
                        if (r_cnt == '0) begin
                            r_state <= S_IDLE;
                        end else if (w_out_free) begin
                            r_out_valid  <= 1'b1;
                            r_out_sample <= r_buf[r_idx];
                            r_out_last   <= w_last;
                            r_out_done   <= w_last && r_item.stream_end;
                            r_out_over   <= r_over;
                            if (w_last) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_idx <= r_idx + IDX_W'(1);
                            end
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

endmodule
